// ===== hw/rtl/smva_pkg.sv =====
// Shared types and constants for the sparse matrix-vector accumulate core.
`timescale 1ns / 1ps

package smva_pkg;

    // Field widths
    localparam int IDX_W     = 12;
    localparam int VAL_W     = 32;
    localparam int ACC_W     = 64;
    localparam int FRAC_W    = 24;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 1;

    typedef logic [CMD_W-1:0]     t_cmd;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic signed [ACC_W-1:0] t_acc;

    // Commands
    localparam t_cmd CMD_LOAD = 2'd0;
    localparam t_cmd CMD_EDGE = 2'd1;
    localparam t_cmd CMD_READ = 2'd2;
    localparam t_cmd CMD_ZERO = 2'd3;

    // Configuration register indexes
    localparam t_cfg_idx CFG_USE_EDGE_WEIGHT = 1'd0;
    localparam t_cfg_idx CFG_DEFAULT_WEIGHT  = 1'd1;

    // Reset values of the configuration registers
    localparam logic USE_EDGE_WEIGHT_RST = 1'b1;
    localparam t_val DEFAULT_WEIGHT_RST  = 32'sd1678;   // 0.0001 in Q8.24

    localparam t_acc ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam t_acc ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

endpackage

// ===== hw/rtl/smva_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module smva_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/sparse_matrix_vector_accumulate_core.sv =====
// Top level of the sparse matrix-vector accumulate core.
`timescale 1ns / 1ps
//
// Streams commands against an input vector store and an accumulator store,
// each VERTICES entries deep. A request is taken at a rising edge with
// i_start high and o_busy low: load input entry, apply edge (accumulator of
// i_vertex_index gains weight * input[i_neighbor_index], Q8.24 product
// floored to 24 fraction bits, saturating 64-bit add), read accumulator, or
// zero accumulator. One request per cycle while o_busy is low.
// Only a read gives a result: o_result_strobe is high for one cycle with
// o_accumulator_value, from the result register after stage 2. The
// receiver cannot stall; results are never held.
// Pipeline: input register / RAM read, 32x32 multiply, saturating add and
// accumulator write-back; a one-entry bypass covers back-to-back updates
// of the same vertex.
// Configuration (index 0 use_edge_weight, 1 default_weight) is written on
// i_cfg_valid with o_cfg_ready, which is always high; the weight is chosen
// when a request is taken.
// After reset the accumulator store is zeroed by a sweep over all VERTICES
// entries, one entry per cycle; o_busy is high during the sweep. The input
// store is not cleared.

module sparse_matrix_vector_accumulate_core #(
    parameter int VERTICES = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  smva_pkg::t_cmd              i_command,
    input  smva_pkg::t_idx              i_vertex_index,
    input  smva_pkg::t_idx              i_neighbor_index,
    input  smva_pkg::t_val              i_vector_value,
    input  smva_pkg::t_val              i_edge_weight,
    output logic                        o_result_strobe,
    output smva_pkg::t_acc              o_accumulator_value,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  smva_pkg::t_cfg_idx          i_cfg_index,
    input  logic [smva_pkg::VAL_W-1:0]  i_cfg_data
);

    localparam int AW = $clog2(VERTICES);
    localparam int SUM_W = smva_pkg::ACC_W + 1;
    localparam int ADD_W = 2 * smva_pkg::VAL_W - smva_pkg::FRAC_W;

    // configuration
    logic           r_use_edge_weight;
    smva_pkg::t_val r_default_weight;

    // clearing sweep
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    // stage 1
    logic           r_s1_valid;
    smva_pkg::t_cmd r_s1_cmd;
    logic [AW-1:0]  r_s1_vaddr;
    logic           r_s1_ok;
    smva_pkg::t_val r_s1_weight;

    // stage 2
    logic                 r_s2_valid;
    smva_pkg::t_cmd       r_s2_cmd;
    logic [AW-1:0]        r_s2_vaddr;
    logic                 r_s2_ok;
    logic signed [63:0]   r_s2_prod;

    // bypass of the last accumulator write
    logic           r_fw_valid;
    logic [AW-1:0]  r_fw_addr;
    smva_pkg::t_acc r_fw_data;

    // result
    logic           r_out_strobe;
    smva_pkg::t_acc r_out_value;

    logic                 w_accept;
    logic [31:0]          w_vi_ext;
    logic [31:0]          w_ni_ext;
    logic                 w_vi_ok;
    logic                 w_ni_ok;
    logic [AW-1:0]        w_vaddr;
    logic [AW-1:0]        w_naddr;
    logic                 w_in_we;
    smva_pkg::t_val       w_x;
    logic signed [63:0]   w_s1_prod;
    smva_pkg::t_acc       w_acc_ram;
    smva_pkg::t_acc       w_acc_old;
    logic signed [ADD_W-1:0] w_addend;
    logic [SUM_W-1:0]     w_sum;
    smva_pkg::t_acc       n_s2_acc;
    logic                 w_s2_we;
    logic                 w_acc_we;
    logic [AW-1:0]        w_acc_waddr;
    smva_pkg::t_acc       w_acc_wdata;

    assign o_busy      = r_clearing;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_start && !r_clearing;

    // index checks against the configured depth
    assign w_vi_ext = 32'(i_vertex_index);
    assign w_ni_ext = 32'(i_neighbor_index);
    assign w_vi_ok  = w_vi_ext < 32'(VERTICES);
    assign w_ni_ok  = w_ni_ext < 32'(VERTICES);
    assign w_vaddr  = w_vi_ext[AW-1:0];
    assign w_naddr  = w_ni_ext[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_edge_weight <= smva_pkg::USE_EDGE_WEIGHT_RST;
            r_default_weight  <= smva_pkg::DEFAULT_WEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                smva_pkg::CFG_USE_EDGE_WEIGHT: r_use_edge_weight <= i_cfg_data[0];
                smva_pkg::CFG_DEFAULT_WEIGHT:  r_default_weight  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == AW'(VERTICES - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // input vector store: loads write on acceptance, edges read the source
    assign w_in_we = w_accept && (i_command == smva_pkg::CMD_LOAD) && w_vi_ok;

    smva_ram #(
        .WIDTH (smva_pkg::VAL_W),
        .DEPTH (VERTICES)
    ) u_in_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_we),
        .i_waddr (w_vaddr),
        .i_wdata (i_vector_value),
        .i_raddr (w_naddr),
        .o_rdata (w_x)
    );

    // stage 1: input entry arrives, multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_cmd    <= i_command;
        r_s1_vaddr  <= w_vaddr;
        r_s1_ok     <= w_vi_ok && ((i_command != smva_pkg::CMD_EDGE) || w_ni_ok);
        r_s1_weight <= r_use_edge_weight ? i_edge_weight : r_default_weight;
    end

    assign w_s1_prod = r_s1_weight * w_x;

    // stage 2: accumulator arrives, saturating add, write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_cmd   <= r_s1_cmd;
        r_s2_vaddr <= r_s1_vaddr;
        r_s2_ok    <= r_s1_ok;
        r_s2_prod  <= w_s1_prod;
    end

    // the RAM read misses a write made at the same edge: take it from the bypass
    assign w_acc_old = (r_fw_valid && (r_fw_addr == r_s2_vaddr)) ? r_fw_data : w_acc_ram;

    // floor to 24 fraction bits
    assign w_addend = r_s2_prod[63:smva_pkg::FRAC_W];
    assign w_sum    = {w_acc_old[smva_pkg::ACC_W-1], w_acc_old}
                    + {{(SUM_W-ADD_W){w_addend[ADD_W-1]}}, w_addend};

    always_comb begin
        if (r_s2_cmd == smva_pkg::CMD_ZERO) begin
            n_s2_acc = '0;
        end else if (w_sum[SUM_W-1] != w_sum[SUM_W-2]) begin
            n_s2_acc = w_sum[SUM_W-1] ? smva_pkg::ACC_MIN : smva_pkg::ACC_MAX;
        end else begin
            n_s2_acc = w_sum[smva_pkg::ACC_W-1:0];
        end
    end

    assign w_s2_we = r_s2_valid && r_s2_ok
                  && ((r_s2_cmd == smva_pkg::CMD_EDGE) || (r_s2_cmd == smva_pkg::CMD_ZERO));

    assign w_acc_we    = r_clearing || w_s2_we;
    assign w_acc_waddr = r_clearing ? r_clr_addr : r_s2_vaddr;
    assign w_acc_wdata = r_clearing ? '0 : n_s2_acc;

    smva_ram #(
        .WIDTH (smva_pkg::ACC_W),
        .DEPTH (VERTICES)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (w_acc_we),
        .i_waddr (w_acc_waddr),
        .i_wdata (w_acc_wdata),
        .i_raddr (r_s1_vaddr),
        .o_rdata (w_acc_ram)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_valid <= 1'b0;
        end else begin
            r_fw_valid <= w_s2_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fw_addr <= r_s2_vaddr;
        r_fw_data <= n_s2_acc;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_strobe <= 1'b0;
        end else begin
            r_out_strobe <= r_s2_valid && (r_s2_cmd == smva_pkg::CMD_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value <= r_s2_ok ? w_acc_old : '0;
    end

    assign o_result_strobe     = r_out_strobe;
    assign o_accumulator_value = r_out_value;

endmodule

// ===== hw/rtl/smva_checker.sv =====
// Port-level checks for the sparse matrix-vector accumulate core, with bind.
`timescale 1ns / 1ps

module smva_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_start,
    input logic           o_busy,
    input smva_pkg::t_cmd i_command,
    input smva_pkg::t_idx i_vertex_index,
    input logic           o_result_strobe,
    input smva_pkg::t_acc o_accumulator_value
);

    logic w_read_req;
    logic w_zero_req;

    assign w_read_req = i_start && !o_busy && (i_command == smva_pkg::CMD_READ);
    assign w_zero_req = i_start && !o_busy && (i_command == smva_pkg::CMD_ZERO);

    // every read request gives a result strobe
    a_read_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_read_req |-> ##3 o_result_strobe)
        else $error("read request without result");

    // no result without a read request
    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(w_read_req, 3))
        else $error("result without read request");

    // busy only rises through reset
    a_busy_stays_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(o_busy)) |-> !o_busy)
        else $error("busy rose outside reset");

    // a read right after a zero of the same vertex sees zero (bypass path)
    a_zero_then_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_zero_req ##1 (w_read_req && (i_vertex_index == $past(i_vertex_index)))
        |-> ##3 (o_result_strobe && (o_accumulator_value == '0)))
        else $error("read after zero returned nonzero");

endmodule

bind sparse_matrix_vector_accumulate_core smva_checker u_smva_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_start             (i_start),
    .o_busy              (o_busy),
    .i_command           (i_command),
    .i_vertex_index      (i_vertex_index),
    .o_result_strobe     (o_result_strobe),
    .o_accumulator_value (o_accumulator_value)
);

// ===== tb/sparse_matrix_vector_accumulate_checker.sv =====
// Checker for the sparse matrix-vector accumulate core: tracks vector and accumulator stores.
`timescale 1ns / 1ps

module sparse_matrix_vector_accumulate_checker #(
    parameter int VERTICES = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  smva_pkg::t_cmd              i_command,
    input  smva_pkg::t_idx              i_vertex_index,
    input  smva_pkg::t_idx              i_neighbor_index,
    input  smva_pkg::t_val              i_vector_value,
    input  smva_pkg::t_val              i_edge_weight,
    input  logic                        i_result_strobe,
    input  smva_pkg::t_acc              i_accumulator_value,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  smva_pkg::t_cfg_idx          i_cfg_index,
    input  logic [smva_pkg::VAL_W-1:0]  i_cfg_data,
    output int                          o_fail_count,
    output int                          o_reads_pending,
    output int                          o_reads_checked,
    output int                          o_edges_applied
);
    import smva_pkg::*;

    t_val vector_store [VERTICES];
    t_acc acc_store [VERTICES];
    logic use_edge_w;
    t_val dflt_weight;
    t_acc acc_reads_due [$];
    int   n_fail;
    int   n_checked;
    int   n_edges;
    t_acc due_val;
    t_val weight;

    // floor(w * x / 2^24); the 64-bit product is exact for 32-bit operands
    function automatic t_acc weighted_term(t_val w, t_val x);
        logic signed [63:0] prod;
        prod = $signed({{32{w[31]}}, w}) * $signed({{32{x[31]}}, x});
        return prod >>> FRAC_W;
    endfunction

    function automatic t_acc sat_sum(t_acc a, t_acc b);
        t_acc s;
        s = a + b;
        if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1])
            return a[ACC_W-1] ? ACC_MIN : ACC_MAX;
        return s;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            use_edge_w  = USE_EDGE_WEIGHT_RST;
            dflt_weight = DEFAULT_WEIGHT_RST;
            foreach (acc_store[k])
                acc_store[k] = '0;
            acc_reads_due.delete();
            n_fail    = 0;
            n_checked = 0;
            n_edges   = 0;
        end else begin
            // results are checked before the request of this edge is predicted
            if (i_result_strobe) begin
                if (acc_reads_due.size() == 0) begin
                    $display("%0t ERROR result with no read outstanding: expected none, got %0d",
                             $time, i_accumulator_value);
                    n_fail++;
                end else begin
                    due_val = acc_reads_due.pop_front();
                    n_checked++;
                    if (i_accumulator_value !== due_val) begin
                        $display("%0t ERROR accumulator_value: expected %0d, got %0d",
                                 $time, due_val, i_accumulator_value);
                        n_fail++;
                    end
                end
            end

            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_USE_EDGE_WEIGHT: use_edge_w = i_cfg_data[0];
                    CFG_DEFAULT_WEIGHT:  dflt_weight = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_start && !i_busy) begin
                case (i_command)
                    CMD_LOAD: begin
                        if (i_vertex_index < VERTICES)
                            vector_store[i_vertex_index] = i_vector_value;
                    end
                    CMD_EDGE: begin
                        if (i_vertex_index < VERTICES && i_neighbor_index < VERTICES) begin
                            weight = use_edge_w ? i_edge_weight : dflt_weight;
                            acc_store[i_vertex_index] = sat_sum(acc_store[i_vertex_index],
                                weighted_term(weight, vector_store[i_neighbor_index]));
                            n_edges++;
                        end
                    end
                    CMD_READ: begin
                        acc_reads_due.push_back(i_vertex_index < VERTICES ?
                                                acc_store[i_vertex_index] : t_acc'(0));
                    end
                    CMD_ZERO: begin
                        if (i_vertex_index < VERTICES)
                            acc_store[i_vertex_index] = '0;
                    end
                    default: ;
                endcase
            end
        end
        o_fail_count    <= n_fail;
        o_reads_pending <= acc_reads_due.size();
        o_reads_checked <= n_checked;
        o_edges_applied <= n_edges;
    end

endmodule

// ===== tb/sparse_matrix_vector_accumulate_core_tb.sv =====
// Testbench top for the sparse matrix-vector accumulate core: stimulus and verdict.
`timescale 1ns / 1ps

module sparse_matrix_vector_accumulate_core_tb;
    import smva_pkg::*;

    localparam int VERTICES = 4096;
    localparam int LATENCY  = 3;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_start;
    logic   o_busy;
    t_cmd   i_command;
    t_idx   i_vertex_index;
    t_idx   i_neighbor_index;
    t_val   i_vector_value;
    t_val   i_edge_weight;
    logic   o_result_strobe;
    t_acc   o_accumulator_value;
    logic   i_cfg_valid;
    logic   o_cfg_ready;
    t_cfg_idx i_cfg_index;
    logic [VAL_W-1:0] i_cfg_data;

    int fail_count;
    int reads_pending;
    int reads_checked;
    int edges_applied;

    // source entries that have been loaded; edges only read these
    bit   loaded_map [VERTICES];
    t_idx loaded_list [$];
    int   n_requests;
    int   n_reg_writes;

    sparse_matrix_vector_accumulate_core #(.VERTICES(VERTICES)) DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (i_start),
        .o_busy              (o_busy),
        .i_command           (i_command),
        .i_vertex_index      (i_vertex_index),
        .i_neighbor_index    (i_neighbor_index),
        .i_vector_value      (i_vector_value),
        .i_edge_weight       (i_edge_weight),
        .o_result_strobe     (o_result_strobe),
        .o_accumulator_value (o_accumulator_value),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    sparse_matrix_vector_accumulate_checker #(.VERTICES(VERTICES)) u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (i_start),
        .i_busy              (o_busy),
        .i_command           (i_command),
        .i_vertex_index      (i_vertex_index),
        .i_neighbor_index    (i_neighbor_index),
        .i_vector_value      (i_vector_value),
        .i_edge_weight       (i_edge_weight),
        .i_result_strobe     (o_result_strobe),
        .i_accumulator_value (o_accumulator_value),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_fail_count        (fail_count),
        .o_reads_pending     (reads_pending),
        .o_reads_checked     (reads_checked),
        .o_edges_applied     (edges_applied)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // leaves i_start high; the caller lowers it for a gap or at the end
    task automatic send(t_cmd cmd, t_idx vtx, t_idx nbr, t_val val, t_val wgt);
        i_start          <= 1'b1;
        i_command        <= cmd;
        i_vertex_index   <= vtx;
        i_neighbor_index <= nbr;
        i_vector_value   <= val;
        i_edge_weight    <= wgt;
        do @(posedge i_clk); while (o_busy);
        n_requests++;
        if (cmd == CMD_LOAD && !loaded_map[vtx]) begin
            loaded_map[vtx] = 1'b1;
            loaded_list.push_back(vtx);
        end
    endtask

    // wait out all reads, then let edge and zero requests retire
    task automatic drain();
        i_start <= 1'b0;
        do @(posedge i_clk); while (reads_pending != 0);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [VAL_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        n_reg_writes++;
    endtask

    // mostly a few hot vertices at both ends of the range so sums build up
    function automatic t_idx pick_vertex();
        int h;
        if ($urandom_range(0, 3) == 0)
            return t_idx'($urandom_range(0, VERTICES - 1));
        h = $urandom_range(0, 15);
        return h < 8 ? t_idx'(h) : t_idx'(VERTICES - 16 + h);
    endfunction

    function automatic t_val pick_q824();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom_range(0, 1) ? 32'h0100_0000 : 32'hFF00_0000;
            3:       return t_val'($urandom_range(0, 255)) - 128;
            default: return t_val'($urandom);
        endcase
    endfunction

    task automatic run_random(int count, bit with_gaps);
        int   r;
        t_idx nbr;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (loaded_list.size() == 0 || r < 15) begin
                send(CMD_LOAD, pick_vertex(), t_idx'($urandom), pick_q824(), t_val'($urandom));
            end else if (r < 70) begin
                nbr = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
                send(CMD_EDGE, pick_vertex(), nbr, t_val'($urandom), pick_q824());
            end else if (r < 90) begin
                send(CMD_READ, pick_vertex(), t_idx'($urandom), t_val'($urandom),
                     t_val'($urandom));
            end else begin
                send(CMD_ZERO, pick_vertex(), t_idx'($urandom), t_val'($urandom),
                     t_val'($urandom));
            end
            if (with_gaps && $urandom_range(0, 5) == 0) begin
                i_start <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_start          = 1'b0;
        i_command        = CMD_LOAD;
        i_vertex_index   = '0;
        i_neighbor_index = '0;
        i_vector_value   = '0;
        i_edge_weight    = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = CFG_USE_EDGE_WEIGHT;
        i_cfg_data       = '0;
        n_requests       = 0;
        n_reg_writes     = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: cleared accumulators, operand extremes, floor rounding, hazards
        send(CMD_READ, 12'd0,    12'd0, 32'h0, 32'h0);
        send(CMD_READ, 12'd4095, 12'd4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(CMD_LOAD, 12'd0,    12'd0, 32'h0100_0000, 32'h0);
        send(CMD_LOAD, 12'd4095, 12'd0, 32'h7FFF_FFFF, 32'h0);
        send(CMD_LOAD, 12'd1,    12'd0, 32'h8000_0000, 32'h0);
        send(CMD_LOAD, 12'd2,    12'd0, 32'hFFFF_FFFF, 32'h0);
        send(CMD_LOAD, 12'd4094, 12'd0, 32'h0000_0001, 32'h0);
        send(CMD_EDGE, 12'd5,    12'd0, 32'h0, 32'h0200_0000);
        send(CMD_EDGE, 12'd5,    12'd0, 32'h0, 32'h0200_0000);
        send(CMD_EDGE, 12'd6,    12'd4095, 32'h0, 32'h7FFF_FFFF);
        send(CMD_EDGE, 12'd6,    12'd1, 32'h0, 32'h8000_0000);
        send(CMD_EDGE, 12'd7,    12'd4095, 32'h0, 32'h8000_0000);
        send(CMD_EDGE, 12'd8,    12'd2, 32'h0, 32'h0000_0001);    // -tiny floors to -1
        send(CMD_EDGE, 12'd4095, 12'd4094, 32'h0, 32'h0000_0001); // +tiny floors to 0
        send(CMD_READ, 12'd5,    12'd0, 32'h0, 32'h0);
        send(CMD_READ, 12'd6,    12'd0, 32'h0, 32'h0);
        send(CMD_READ, 12'd7,    12'd0, 32'h0, 32'h0);
        send(CMD_READ, 12'd8,    12'd0, 32'h0, 32'h0);
        send(CMD_READ, 12'd4095, 12'd0, 32'h0, 32'h0);
        send(CMD_LOAD, 12'd3,    12'd0, 32'h0100_0000, 32'h0);
        send(CMD_EDGE, 12'd10,   12'd3, 32'h0, 32'hFF00_0000);    // load then use at once
        send(CMD_READ, 12'd10,   12'd0, 32'h0, 32'h0);
        send(CMD_ZERO, 12'd6,    12'd0, 32'h0, 32'h0);
        send(CMD_EDGE, 12'd6,    12'd0, 32'h0, 32'h0100_0000);
        send(CMD_READ, 12'd6,    12'd0, 32'h0, 32'h0);
        drain();

        // default weight still at its reset value
        write_reg(CFG_USE_EDGE_WEIGHT, 32'd0);
        run_random(150, 1'b1);
        drain();
        write_reg(CFG_DEFAULT_WEIGHT, 32'h7FFF_FFFF);
        run_random(150, 1'b1);
        drain();
        write_reg(CFG_DEFAULT_WEIGHT, 32'h8000_0000);
        run_random(150, 1'b1);
        drain();
        write_reg(CFG_USE_EDGE_WEIGHT, 32'd1);
        write_reg(CFG_DEFAULT_WEIGHT, 32'd0);
        run_random(250, 1'b1);
        drain();
        write_reg(CFG_USE_EDGE_WEIGHT, 32'd0);
        write_reg(CFG_DEFAULT_WEIGHT, $urandom);
        run_random(150, 1'b1);
        drain();
        write_reg(CFG_USE_EDGE_WEIGHT, 32'd1);
        run_random(250, 1'b0);
        drain();

        $display("Covered %0d requests (%0d edges applied), %0d accumulator reads checked,",
                 n_requests, edges_applied, reads_checked);
        $display("%0d register writes over six weight settings", n_reg_writes);
        if (fail_count == 0 && reads_pending == 0) begin
            $display("PASS sparse_matrix_vector_accumulate_core");
        end else begin
            $display("%0d mismatches, %0d reads never answered", fail_count, reads_pending);
            $display("FAIL sparse_matrix_vector_accumulate_core");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout waiting on the core");
        $display("FAIL sparse_matrix_vector_accumulate_core");
        $finish;
    end

endmodule
